[rtl/core/cde_pkg.sv]
package cde_pkg;

    localparam int CDE_QUEUE_DEPTH = 2;

    localparam logic [13:0] YEAR_LOW_MAX  = 14'd69;
    localparam logic [13:0] YEAR_MID_MAX  = 14'd99;
    localparam logic [13:0] YEAR_LOW_ADD  = 14'd2000;
    localparam logic [13:0] YEAR_MID_ADD  = 14'd1900;
    localparam logic [13:0] EPOCH_YEAR    = 14'd1970;

    // first three letters, first letter in the low byte
    localparam logic [23:0] MONTH_KEYS [12] = '{
        "naj", "bef", "ram", "rpa", "yam", "nuj",
        "luj", "gua", "pes", "tco", "von", "ced"
    };

    typedef enum logic [4:0] {
        PH_LEAD = 5'b00001,
        PH_MIN  = 5'b00010,
        PH_SEC  = 5'b00100,
        PH_DONE = 5'b01000,
        PH_DEAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        in_token;
        t_phase      phase;
        logic [2:0]  lead_cnt;
        logic [13:0] lead_num;
        logic [6:0]  p2_val;
        logic [1:0]  p2_cnt;
        logic [6:0]  p3_val;
        logic [1:0]  p3_cnt;
        logic [23:0] prefix;
        logic [1:0]  prefix_cnt;
    } t_tok;

    localparam t_tok TOK_CLEAR = '{
        in_token: 1'b0, phase: PH_LEAD, lead_cnt: '0, lead_num: '0,
        p2_val: '0, p2_cnt: '0, p3_val: '0, p3_cnt: '0,
        prefix: '0, prefix_cnt: '0
    };

    typedef struct packed {
        logic [3:0]  found;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_fields;

    typedef struct packed {
        logic        valid;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_month_hit;

    function automatic logic cde_is_delim(input logic [7:0] b);
        logic r;
        r = (b == 8'h00) || (b == 8'h09) ||
            (b inside {[8'h20:8'h2F], [8'h3B:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
        return r;
    endfunction

    function automatic t_month_hit cde_month_lookup(input logic [23:0] key);
        t_month_hit r;
        r = '0;
        for (int i = 11; i >= 0; i--) begin
            if (key == MONTH_KEYS[i]) begin
                r.hit = 1'b1;
                r.idx = 4'(i);
            end
        end
        return r;
    endfunction

    // day offset of the month's first day in a March-based year
    function automatic logic [8:0] cde_doy(input logic [3:0] month);
        logic [8:0] r;
        case (month)
            4'd0:    r = 9'd306;
            4'd1:    r = 9'd337;
            4'd2:    r = 9'd0;
            4'd3:    r = 9'd31;
            4'd4:    r = 9'd61;
            4'd5:    r = 9'd92;
            4'd6:    r = 9'd122;
            4'd7:    r = 9'd153;
            4'd8:    r = 9'd184;
            4'd9:    r = 9'd214;
            4'd10:   r = 9'd245;
            4'd11:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cde_if.sv]
interface cde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface cde_out_if;
    logic        valid;
    logic        ready;
    logic [37:0] epoch_seconds;
    logic        date_valid;

    modport source (output valid, output epoch_seconds, output date_valid, input ready);
    modport sink   (input valid, input epoch_seconds, input date_valid, output ready);
endinterface

[rtl/core/cde_front.sv]
module cde_front
    import cde_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    cde_in_if.sink         i_in,
    input  t_q_stat        i_stat,
    output t_push          o_push
);

    t_tok       r_tok, n_tok;
    t_fields    r_fld, n_fld;

    t_tok       fed, sel;
    t_fields    fld_end;
    t_month_hit mhit;
    logic [7:0] b, low;
    logic [3:0] d;
    logic       dig, delim, do_end, accept, time_ok, month_hit;

    assign i_in.ready = !i_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        b     = i_in.text_byte;
        dig   = b inside {[8'h30:8'h39]};
        d     = b[3:0];
        low   = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
        delim = cde_is_delim(b);

        fed          = r_tok;
        fed.in_token = 1'b1;
        if (r_tok.prefix_cnt != 2'd3) begin
            fed.prefix[8*r_tok.prefix_cnt +: 8] = low;
            fed.prefix_cnt = r_tok.prefix_cnt + 2'd1;
        end
        case (r_tok.phase)
            PH_LEAD: begin
                if (dig) begin
                    if (r_tok.lead_cnt < 3'd4) begin
                        fed.lead_num = 14'(r_tok.lead_num * 14'd10 + {10'd0, d});
                        fed.lead_cnt = r_tok.lead_cnt + 3'd1;
                    end else begin
                        fed.lead_cnt = 3'd5;
                    end
                end else if (b == ":" && r_tok.lead_cnt inside {[3'd1:3'd2]}) begin
                    fed.phase = PH_MIN;
                end else begin
                    fed.phase = PH_DEAD;
                end
            end
            PH_MIN: begin
                if (dig) begin
                    if (r_tok.p2_cnt < 2'd2) begin
                        fed.p2_val = 7'(r_tok.p2_val * 7'd10 + {3'd0, d});
                        fed.p2_cnt = r_tok.p2_cnt + 2'd1;
                    end else begin
                        fed.phase = PH_DEAD;
                    end
                end else begin
                    fed.phase = (b == ":" && r_tok.p2_cnt != 2'd0) ? PH_SEC : PH_DEAD;
                end
            end
            PH_SEC: begin
                if (dig) begin
                    if (r_tok.p3_cnt < 2'd2) begin
                        fed.p3_val = 7'(r_tok.p3_val * 7'd10 + {3'd0, d});
                        fed.p3_cnt = r_tok.p3_cnt + 2'd1;
                    end else begin
                        fed.phase = PH_DEAD;
                    end
                end else begin
                    fed.phase = (r_tok.p3_cnt != 2'd0) ? PH_DONE : PH_DEAD;
                end
            end
            default: ;
        endcase

        sel    = delim ? r_tok : fed;
        do_end = delim ? r_tok.in_token : i_in.last_byte;

        // classify the finished token
        fld_end   = r_fld;
        mhit      = cde_month_lookup(sel.prefix);
        time_ok   = (sel.phase == PH_DONE) || (sel.phase == PH_SEC && sel.p3_cnt != 2'd0);
        month_hit = 1'b0;
        if (do_end) begin
            if (!r_fld.found[0] && time_ok) begin
                fld_end.hour     = sel.lead_num[6:0];
                fld_end.minute   = sel.p2_val;
                fld_end.second   = sel.p3_val;
                fld_end.found[0] = 1'b1;
            end else if (!r_fld.found[1] && sel.lead_cnt inside {[3'd1:3'd2]}) begin
                fld_end.day      = sel.lead_num[6:0];
                fld_end.found[1] = 1'b1;
            end else begin
                month_hit = !r_fld.found[2] && sel.prefix_cnt == 2'd3 && mhit.hit;
                if (month_hit) begin
                    fld_end.month    = mhit.idx;
                    fld_end.found[2] = 1'b1;
                end
                if (!month_hit && !r_fld.found[3] && sel.lead_cnt inside {[3'd2:3'd4]}) begin
                    fld_end.year     = sel.lead_num;
                    fld_end.found[3] = 1'b1;
                end
            end
        end

        n_tok = (delim || i_in.last_byte) ? TOK_CLEAR : fed;
        n_fld = i_in.last_byte ? '0 : fld_end;

        o_push.valid      = accept && i_in.last_byte;
        o_push.job.valid  = fld_end.found == 4'hF;
        o_push.job.hour   = fld_end.hour;
        o_push.job.minute = fld_end.minute;
        o_push.job.second = fld_end.second;
        o_push.job.day    = fld_end.day;
        o_push.job.month  = fld_end.month;
        o_push.job.year   = fld_end.year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= TOK_CLEAR;
            r_fld <= '0;
        end else if (accept) begin
            r_tok <= n_tok;
            r_fld <= n_fld;
        end
    end

endmodule

[rtl/core/cde_queue.sv]
module cde_queue
    import cde_pkg::*;
#(
    parameter int Depth = CDE_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_stat.full  = r_cnt == CntW'(Depth);
    assign o_stat.empty = r_cnt == '0;
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

[rtl/core/cde_back.sv]
module cde_back
    import cde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_head,
    input  t_q_stat  i_stat,
    output logic     o_pop,
    cde_out_if.source o_out
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_DAYS = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_SUM  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    localparam logic [11:0]        DIV25_K  = 12'd2622;
    localparam logic [23:0]        DAY_BIAS = 24'd719469;
    localparam logic signed [41:0] DAY_SECS = 42'sd86400;

    t_state              r_state;
    t_job                r_job;
    logic [13:0]         r_ys;
    logic [8:0]          r_doy;
    logic                r_zero;
    logic [18:0]         r_tsec;
    logic [7:0]          r_cent;
    logic [23:0]         r_days;
    logic signed [41:0]  r_dsec;
    logic [37:0]         r_epoch;
    logic                r_dvalid;

    logic [13:0]         ya;
    logic [11:0]         q;
    logic [23:0]         prod;
    logic [23:0]         days;
    logic signed [41:0]  total;

    assign o_pop               = (r_state == ST_IDLE) && !i_stat.empty;
    assign o_out.valid         = r_state == ST_OUT;
    assign o_out.epoch_seconds = r_epoch;
    assign o_out.date_valid    = r_dvalid;

    always_comb begin
        if (r_job.year <= YEAR_LOW_MAX) begin
            ya = r_job.year + YEAR_LOW_ADD;
        end else if (r_job.year <= YEAR_MID_MAX) begin
            ya = r_job.year + YEAR_MID_ADD;
        end else begin
            ya = r_job.year;
        end
        q    = r_ys[13:2];
        prod = {12'd0, q} * {12'd0, DIV25_K};
        days = {10'd0, r_ys} * 24'd365 + {12'd0, q} - {16'd0, r_cent}
             + {18'd0, r_cent[7:2]} + {15'd0, r_doy} + {17'd0, r_job.day} - DAY_BIAS;
        total = r_dsec + $signed({23'd0, r_tsec});
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (o_pop) r_job <= i_head;
            ST_PREP: begin
                r_zero <= !r_job.valid || (ya < EPOCH_YEAR);
                r_ys   <= ya - ((r_job.month < 4'd2) ? 14'd1 : 14'd0);
                r_doy  <= cde_doy(r_job.month);
                r_tsec <= {12'd0, r_job.hour} * 19'd3600 + {12'd0, r_job.minute} * 19'd60
                        + {12'd0, r_job.second};
            end
            ST_DIV:  r_cent <= prod[23:16];
            ST_DAYS: r_days <= days;
            ST_MUL:  r_dsec <= $signed({{18{r_days[23]}}, r_days}) * DAY_SECS;
            ST_SUM: begin
                r_epoch  <= (r_zero || total[41]) ? '0 : total[37:0];
                r_dvalid <= r_job.valid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: if (o_pop) r_state <= ST_PREP;
                ST_PREP: r_state <= ST_DIV;
                ST_DIV:  r_state <= ST_DAYS;
                ST_DAYS: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_OUT;
                ST_OUT:  if (o_out.ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/cookie_date_to_epoch.sv]
// Cookie date to epoch seconds.
// i_in takes the date string one byte per word; last_byte marks the final
// byte of a string. o_out gives one word per string: epoch_seconds (UTC) and
// date_valid, which is 0 (with seconds 0) when time, day, month or year was
// not found.
// The tokenizer accepts one byte per cycle. On the last byte the collected
// fields go into a small queue (QueueDepth strings); i_in.ready drops only
// while that queue is full.
// The converter takes one string at a time and is shared by all strings: when
// it is free, the string is popped and goes through six steps (pop, prep,
// divide, days, multiply, sum, with the multiplies spread over them), then
// o_out.valid rises; the next string is taken only after the handoff.
// A stalled receiver holds the result in the output register; bytes keep
// flowing until the queue fills.
// Reset (synchronous, active low) clears the token and field state, the
// queue and the converter; o_out.valid is low after reset.
module cookie_date_to_epoch
    import cde_pkg::*;
#(
    parameter int QueueDepth = CDE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cde_in_if.sink     i_in,
    cde_out_if.source  o_out
);

    t_push   push;
    t_job    head;
    t_q_stat q_stat;
    logic    pop;

    cde_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_push  (push)
    );

    cde_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    cde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_stat.full)
        else $error("string pushed into full queue");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready |=> !o_out.valid)
        else $error("result repeated after handoff");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.date_valid |-> o_out.epoch_seconds == '0)
        else $error("invalid date with nonzero seconds");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

[tb/sv/cookie_date_to_epoch_tb.sv]
module cookie_date_to_epoch_tb;
    import cde_pkg::*;

    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_CYCLES = 24;
    localparam int TOTAL_BYTES = 400;
    localparam int RANDOM_DATES = 3;
    localparam int TAIL_BYTES = 100;

    localparam logic [23:0] MONTH_ABBR [12] = '{
        "jan", "feb", "mar", "apr", "may", "jun",
        "jul", "aug", "sep", "oct", "nov", "dec"
    };

    typedef struct {
        logic [7:0] text;
        logic       last;
    } text_word_t;

    typedef struct {
        logic [37:0] secs;
        logic        ok;
    } epoch_word_t;

    logic i_clk;
    logic i_rst_n;

    cde_in_if  in_if ();
    cde_out_if out_if ();

    cookie_date_to_epoch dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    text_word_t  text_q [$];
    epoch_word_t epoch_due [$];

    int   err_count = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic in_taken = 1'b0;
    logic quiet = 1'b0;

    // parser state
    logic        tok_open;
    t_phase      tok_phase;
    logic [2:0]  lead_cnt;
    logic [13:0] lead_num;
    logic [6:0]  mm_val;
    logic [1:0]  mm_cnt;
    logic [6:0]  ss_val;
    logic [1:0]  ss_cnt;
    logic [23:0] prefix;
    logic [1:0]  prefix_cnt;
    logic [3:0]  fld_found;
    logic [6:0]  fld_hour;
    logic [6:0]  fld_min;
    logic [6:0]  fld_sec;
    logic [6:0]  fld_day;
    logic [3:0]  fld_mon;
    logic [13:0] fld_year;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic sep_char(input logic [7:0] b);
        case (b) inside
            8'h00, 8'h09, [8'h20:8'h2F], [8'h3B:8'h40],
            [8'h5B:8'h60], [8'h7B:8'h7E]: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic no_idle();
        return quiet || (text_q.size() < TAIL_BYTES);
    endfunction

    task automatic clear_token();
        tok_open = 1'b0;
        tok_phase = PH_LEAD;
        lead_cnt = '0;
        lead_num = '0;
        mm_val = '0;
        mm_cnt = '0;
        ss_val = '0;
        ss_cnt = '0;
        prefix = '0;
        prefix_cnt = '0;
    endtask

    task automatic clear_fields();
        fld_found = '0;
        fld_hour = '0;
        fld_min = '0;
        fld_sec = '0;
        fld_day = '0;
        fld_mon = '0;
        fld_year = '0;
        clear_token();
    endtask

    task automatic feed_char(input logic [7:0] b);
        logic       is_dig;
        logic [3:0] d;
        logic [7:0] low;
        is_dig = (b >= "0") && (b <= "9");
        d = is_dig ? 4'(b - 8'h30) : 4'd0;
        tok_open = 1'b1;
        if (prefix_cnt < 2'd3) begin
            low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            prefix = prefix | (24'(low) << (8 * prefix_cnt));
            prefix_cnt = prefix_cnt + 2'd1;
        end
        case (tok_phase)
            PH_LEAD: begin
                if (is_dig) begin
                    if (lead_cnt < 3'd4) begin
                        lead_num = lead_num * 14'd10 + 14'(d);
                        lead_cnt = lead_cnt + 3'd1;
                    end else begin
                        lead_cnt = 3'd5;
                    end
                end else if (b == ":" && lead_cnt >= 3'd1 && lead_cnt <= 3'd2) begin
                    tok_phase = PH_MIN;
                end else begin
                    tok_phase = PH_DEAD;
                end
            end
            PH_MIN: begin
                if (is_dig) begin
                    if (mm_cnt < 2'd2) begin
                        mm_val = mm_val * 7'd10 + 7'(d);
                        mm_cnt = mm_cnt + 2'd1;
                    end else begin
                        tok_phase = PH_DEAD;
                    end
                end else begin
                    tok_phase = (b == ":" && mm_cnt >= 2'd1) ? PH_SEC : PH_DEAD;
                end
            end
            PH_SEC: begin
                if (is_dig) begin
                    if (ss_cnt < 2'd2) begin
                        ss_val = ss_val * 7'd10 + 7'(d);
                        ss_cnt = ss_cnt + 2'd1;
                    end else begin
                        tok_phase = PH_DEAD;
                    end
                end else begin
                    tok_phase = (ss_cnt >= 2'd1) ? PH_DONE : PH_DEAD;
                end
            end
            default: ;
        endcase
    endtask

    task automatic close_token();
        logic        time_ok;
        logic        hit;
        logic [23:0] key;
        time_ok = (tok_phase == PH_DONE) || (tok_phase == PH_SEC && ss_cnt >= 2'd1);
        if (!fld_found[0] && time_ok) begin
            fld_hour = lead_num[6:0];
            fld_min = mm_val;
            fld_sec = ss_val;
            fld_found[0] = 1'b1;
        end else if (!fld_found[1] && lead_cnt >= 3'd1 && lead_cnt <= 3'd2) begin
            fld_day = lead_num[6:0];
            fld_found[1] = 1'b1;
        end else begin
            hit = 1'b0;
            key = {prefix[7:0], prefix[15:8], prefix[23:16]};
            if (!fld_found[2] && prefix_cnt == 2'd3) begin
                for (int i = 0; i < 12; i++) begin
                    if (!hit && key == MONTH_ABBR[i]) begin
                        fld_mon = 4'(i);
                        hit = 1'b1;
                    end
                end
                if (hit) fld_found[2] = 1'b1;
            end
            if (!hit && !fld_found[3] && lead_cnt >= 3'd2 && lead_cnt <= 3'd4) begin
                fld_year = lead_num;
                fld_found[3] = 1'b1;
            end
        end
        clear_token();
    endtask

    function automatic logic [37:0] epoch_of_fields();
        longint y, mo, era, yoe, doy, doe, days, total;
        longint dd, hh, mi, ss;
        y = fld_year;
        dd = fld_day;
        hh = fld_hour;
        mi = fld_min;
        ss = fld_sec;
        if (y <= 69) y = y + 2000;
        else if (y <= 99) y = y + 1900;
        if (y < 1970) return '0;
        mo = fld_mon;
        mo = mo + 1;
        if (mo <= 2) y = y - 1;
        era = y / 400;
        yoe = y - era * 400;
        doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468 + dd - 1;
        total = days * 86400 + hh * 3600 + mi * 60 + ss;
        if (total < 0) return '0;
        return total[37:0];
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        epoch_word_t w;
        if (!sep_char(b)) feed_char(b);
        else if (tok_open) close_token();
        if (last) begin
            if (tok_open) close_token();
            if (fld_found == 4'hF) begin
                w.secs = epoch_of_fields();
                w.ok = 1'b1;
            end else begin
                w.secs = '0;
                w.ok = 1'b0;
            end
            epoch_due.push_back(w);
            clear_fields();
        end
    endtask

    // stimulus builders
    task automatic push_byte(input logic [7:0] b);
        text_word_t t;
        t.text = b;
        t.last = 1'b0;
        text_q.push_back(t);
    endtask

    task automatic add_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
        if (close) text_q[text_q.size() - 1].last = 1'b1;
    endtask

    task automatic push_sep_run();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom_range(1, 8'h7E)); while (!sep_char(b));
            push_byte(b);
        end
    endtask

    task automatic push_rand_digits(input int n);
        repeat (n) push_byte(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_number(input int v, input int n);
        int p;
        p = 1;
        repeat (n - 1) p = p * 10;
        for (int i = 0; i < n; i++) begin
            push_byte(8'h30 + 8'((v / p) % 10));
            p = p / 10;
        end
    endtask

    task automatic push_junk_token();
        logic [7:0] b;
        repeat ($urandom_range(1, 5)) begin
            do b = 8'($urandom_range(1, 255)); while (sep_char(b));
            push_byte(b);
        end
    endtask

    task automatic push_time_token();
        int hd;
        hd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
        push_rand_digits(hd);
        push_byte(":");
        push_rand_digits(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2));
        if ($urandom_range(0, 5) != 0) begin
            push_byte(":");
            push_rand_digits(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(1, 2));
        end
        if ($urandom_range(0, 7) == 0) push_junk_token();
    endtask

    task automatic push_month_token();
        logic [23:0] name;
        logic [7:0]  c;
        name = MONTH_ABBR[$urandom_range(0, 11)];
        for (int i = 2; i >= 0; i--) begin
            c = name[8 * i +: 8];
            if ($urandom_range(0, 1) == 1) c = c - 8'd32;
            if ($urandom_range(0, 19) == 0) c = 8'($urandom_range("a", "z"));
            push_byte(c);
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0)
            push_byte(8'($urandom_range("a", "z")));
    endtask

    task automatic push_year_token();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) push_number($urandom_range(0, 99), 2);
        else if (r < 8) push_number($urandom_range(1965, 2105), 4);
        else if (r < 9) push_number($urandom_range(0, 9999), 4);
        else push_rand_digits($urandom_range(1, 6));
    endtask

    task automatic add_random_date();
        int kinds [$];
        int tmp, j;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(1, 255)));
        end else begin
            for (int k = 0; k < 4; k++)
                if ($urandom_range(0, 11) != 0) kinds.push_back(k);
            repeat ($urandom_range(0, 2)) kinds.push_back(4);
            if (kinds.size() == 0) kinds.push_back(4);
            for (int i = kinds.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = kinds[i];
                kinds[i] = kinds[j];
                kinds[j] = tmp;
            end
            if ($urandom_range(0, 3) == 0) push_sep_run();
            foreach (kinds[i]) begin
                if (i > 0) push_sep_run();
                case (kinds[i])
                    0: push_time_token();
                    1: begin
                        push_rand_digits(($urandom_range(0, 9) == 0) ? $urandom_range(3, 5)
                                                                     : $urandom_range(1, 2));
                        if ($urandom_range(0, 7) == 0) push_junk_token();
                    end
                    2: push_month_token();
                    3: push_year_token();
                    default: push_junk_token();
                endcase
            end
            if ($urandom_range(0, 3) == 0) push_sep_run();
        end
        text_q[text_q.size() - 1].last = 1'b1;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_taken) void'(text_q.pop_front());
            if (in_if.valid && !in_taken) begin
                // hold the offered word
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (text_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (!no_idle() && $urandom_range(0, 11) == 0) begin
                gap_left = $urandom_range(0, 13);
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid <= 1'b1;
                in_if.text_byte <= text_q[0].text;
                in_if.last_byte <= text_q[0].last;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!no_idle() && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        epoch_word_t w;
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if ($urandom_range(0, 249) == 0) quiet <= !quiet;
            if (in_if.valid && in_if.ready) parse_byte(in_if.text_byte, in_if.last_byte);
            if (out_if.valid && out_if.ready) begin
                if (epoch_due.size() == 0) begin
                    $display("%0t: unexpected word, epoch_seconds %0d date_valid %0b",
                             $time, out_if.epoch_seconds, out_if.date_valid);
                    err_count++;
                end else begin
                    w = epoch_due.pop_front();
                    if (out_if.epoch_seconds !== w.secs) begin
                        $display("%0t: epoch_seconds expected %0d, got %0d",
                                 $time, w.secs, out_if.epoch_seconds);
                        err_count++;
                    end
                    if (out_if.date_valid !== w.ok) begin
                        $display("%0t: date_valid expected %0b, got %0b",
                                 $time, w.ok, out_if.date_valid);
                        err_count++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        string samples [] = '{
            "Sun, 06 Nov 1994 08:49:37 GMT",
            "Thu, 01 Jan 1970 00:00:00 GMT",
            "31-Dec-9999 23:59:59",
            "nOV 5 94 1:2:3",
            "Jan 1 00 0:0:0",
            "Jun 15 69 12:00:00",
            "Jun 15 1969 12:00:00",
            "Jun 15 0100 12:00:00",
            "00 Jan 1970 00:00:00",
            "Jan 1970 00:00:00",
            ":30:00 7 Mar 2001 10:11:12",
            "123:00:00 7 Mar 2001 10:11:12",
            "1:2x 08 Aug 2010 04:05:06",
            " \t  10 Oct 2020 10:10:10 ",
            "Ja 5 2020 10:10:10 Ma",
            "99:99:99 99 Feb 2000",
            "3 Apr 2003 12:34:5",
            "x",
            " ",
            "2 feb 1970 0:0:0 Sept DECEMBER",
            "JUL 4 1776 07:08:09;jul-4-76"
        };
        int dates;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.text_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        clear_fields();

        foreach (samples[i]) add_text(samples[i], 1'b1);
        push_byte(8'h01);
        push_byte(8'hFF);
        add_text(" 2 May 1999 11:22:33", 1'b0);
        push_byte(8'hFF);
        text_q[text_q.size() - 1].last = 1'b1;

        dates = 0;
        while (text_q.size() < TOTAL_BYTES || dates < RANDOM_DATES) begin
            add_random_date();
            dates++;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || epoch_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
